// File: design/pgpm_pkg.sv
// ----------------------------------------------------------------------------
// pgpm_pkg
// Shared types, register indexes, format codes and fixed-point helpers for
// the PCM gain and peak meter core.
// ----------------------------------------------------------------------------
package pgpm_pkg;

    localparam int PGPM_CHANNELS = 4;
    localparam int GAIN_REGS     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FORMAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SHIFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH3      = 3'd6;

    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S24 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;

    localparam logic GFMT_Q8_16 = 1'b0;
    localparam logic GFMT_Q1_23 = 1'b1;

    localparam logic signed [31:0] GAIN_RESET = 32'sd65536;

    localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
    localparam logic signed [64:0] S32_MIN = -65'sd2147483648;
    localparam logic signed [64:0] S24_MAX = 65'sd8388607;
    localparam logic signed [64:0] S24_MIN = -65'sd8388608;
    localparam logic signed [64:0] S16_MAX = 65'sd32767;
    localparam logic signed [64:0] S16_MIN = -65'sd32768;

    typedef struct packed {
        logic signed [31:0] sample_in;
        logic [1:0]         chan;
        logic               period_start;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample_out;
        logic [1:0]         chan_out;
        logic [30:0]        peak_level;
    } out_item_t;

    typedef struct packed {
        logic       update;
        logic [1:0] chan;
        logic       clear;
        logic       shift_en;
        logic [4:0] shift;
    } peak_ctrl_t;

    // round half away from zero, divide by 2^sh
    function automatic logic signed [64:0] pgpm_rsym(input logic signed [64:0] v,
                                                    input int unsigned sh);
        logic signed [64:0] half;
        logic signed [64:0] bias;
        half = 65'sd1 <<< (sh - 1);
        bias = v[64] ? half - 65'sd1 : half;
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [64:0] pgpm_clamp(input logic signed [64:0] v,
                                                     input logic signed [64:0] lo,
                                                     input logic signed [64:0] hi);
        logic signed [64:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // Q8.16 to Q9.23: shift left 7, saturate to 32 bits
    function automatic logic signed [31:0] pgpm_q923(input logic signed [31:0] g);
        logic signed [31:0] r;
        if (g[31:24] == {8{g[31]}}) begin
            r = g <<< 7;
        end else if (g[31]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// File: design/pgpm_scale.sv
// ----------------------------------------------------------------------------
// pgpm_scale
// Gain multiply, symmetric rounding and saturation for the three formats.
// ----------------------------------------------------------------------------
module pgpm_scale
    import pgpm_pkg::*;
(
    input  logic [1:0]         sample_format,
    input  logic               gain_format,
    input  logic signed [31:0] x,
    input  logic signed [31:0] a,
    output logic signed [31:0] y
);

    logic signed [63:0] prod;
    logic signed [64:0] p65;
    logic signed [64:0] v32;
    logic signed [64:0] r32;
    logic signed [64:0] r24;
    logic signed [64:0] t16;
    logic signed [64:0] r16;

    always_comb begin
        prod = a * x;
        p65  = $signed({prod[63], prod});

        // s32: doubled product, floor shift by 1 or 8, round by 16
        v32 = (gain_format == GFMT_Q1_23) ? (p65 >>> 7) : p65;
        r32 = pgpm_clamp(pgpm_rsym(v32, 16), S32_MIN, S32_MAX);

        // s24: Q9.23 times sample
        r24 = pgpm_clamp(pgpm_rsym(p65, 23), S24_MIN, S24_MAX);

        // s16: round by 15, then by 8 after the 32-bit stage
        t16 = pgpm_clamp(pgpm_rsym(p65, 15), S32_MIN, S32_MAX);
        r16 = pgpm_clamp(pgpm_rsym(t16, 8), S16_MIN, S16_MAX);

        case (sample_format)
            FMT_S16: y = r16[31:0];
            FMT_S24: y = r24[31:0];
            default: y = r32[31:0];
        endcase
    end

endmodule

// File: design/pgpm_peak.sv
// ----------------------------------------------------------------------------
// pgpm_peak
// Per-channel peak store with period clear and saturating peak shift.
// ----------------------------------------------------------------------------
module pgpm_peak
    import pgpm_pkg::*;
#(
    parameter int CHANNELS = PGPM_CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  peak_ctrl_t  ctrl,
    input  logic [30:0] mag,
    output logic [30:0] peak_level
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [30:0]      peak_reg [CHANNELS];
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [30:0]      cur;
    logic [30:0]      peak_next;
    logic [61:0]      shifted;
    logic [30:0]      shifted_sat;

    always_comb begin
        in_range    = (32'(ctrl.chan) < CHANNELS);
        idx         = IDX_W'(ctrl.chan);
        cur         = (in_range && !ctrl.clear) ? peak_reg[idx] : 31'd0;
        peak_next   = (mag > cur) ? mag : cur;
        shifted     = {31'd0, peak_next} << ctrl.shift;
        shifted_sat = (|shifted[61:31]) ? 31'h7FFF_FFFF : shifted[30:0];
        if (!in_range) begin
            peak_level = 31'd0;
        end else if (ctrl.shift_en) begin
            peak_level = shifted_sat;
        end else begin
            peak_level = peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                peak_reg[i] <= 31'd0;
            end
        end else if (ctrl.update && in_range) begin
            peak_reg[idx] <= peak_next;
        end
    end

endmodule

// File: design/pcm_gain_with_peak_meter_core.sv
// ----------------------------------------------------------------------------
// pcm_gain_with_peak_meter_core
// An accepted request goes through the input register, then the result register,
// before its result is valid; one request per cycle while the output is not
// stalled, set by the single multiplier stage. Synchronous active-low reset clears
// handshake state and all channel peaks and restores the configuration defaults.
// ----------------------------------------------------------------------------
module pcm_gain_with_peak_meter_core
    import pgpm_pkg::*;
#(
    parameter int CHANNELS = PGPM_CHANNELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [1:0]         sample_format_reg;
    logic               gain_format_reg;
    logic [4:0]         peak_shift_reg;
    logic signed [31:0] gain_reg [GAIN_REGS];

    logic               in_valid_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] a_reg;
    logic [1:0]         chan_reg;
    logic               clr_reg;

    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic               take;
    logic               advance;
    logic               out_free;
    logic signed [31:0] g_sel;
    logic signed [31:0] x_next;
    logic signed [31:0] a_next;
    logic signed [31:0] y;
    logic [31:0]        x_abs;
    logic [30:0]        mag;
    logic [30:0]        peak_level;
    peak_ctrl_t         pctrl;

    assign cfg_ready = aresetn;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = aresetn && (!in_valid_reg || out_free);
    assign take      = s_valid && s_ready;
    assign advance   = in_valid_reg && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // operand preparation at capture
    always_comb begin
        g_sel = gain_reg[s_data.chan];
        case (sample_format_reg)
            FMT_S16: x_next = 32'(s_data.sample_in[15:0]);
            FMT_S24: x_next = 32'(s_data.sample_in[23:0]);
            default: x_next = s_data.sample_in;
        endcase
        if (sample_format_reg == FMT_S16 || sample_format_reg == FMT_S24) begin
            a_next = (gain_format_reg == GFMT_Q1_23) ? g_sel : pgpm_q923(g_sel);
        end else begin
            a_next = g_sel;
        end
        if (sample_format_reg == FMT_S16) begin
            x_next = $signed({{16{s_data.sample_in[15]}}, s_data.sample_in[15:0]});
        end else if (sample_format_reg == FMT_S24) begin
            x_next = $signed({{8{s_data.sample_in[23]}}, s_data.sample_in[23:0]});
        end
    end

    always_comb begin
        x_abs = x_reg[31] ? (32'd0 - 32'(x_reg)) : 32'(x_reg);
        mag   = x_abs[31] ? 31'h7FFF_FFFF : x_abs[30:0];
    end

    always_comb begin
        pctrl.update   = advance;
        pctrl.chan     = chan_reg;
        pctrl.clear    = clr_reg;
        pctrl.shift_en = (sample_format_reg != FMT_S16);
        pctrl.shift    = peak_shift_reg;
    end

    pgpm_scale u_scale (
        .sample_format (sample_format_reg),
        .gain_format   (gain_format_reg),
        .x             (x_reg),
        .a             (a_reg),
        .y             (y)
    );

    pgpm_peak #(
        .CHANNELS (CHANNELS)
    ) u_peak (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (pctrl),
        .mag        (mag),
        .peak_level (peak_level)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_format_reg <= FMT_S32;
            gain_format_reg   <= GFMT_Q8_16;
            peak_shift_reg    <= 5'd0;
            for (int i = 0; i < GAIN_REGS; i++) begin
                gain_reg[i] <= GAIN_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SAMPLE_FORMAT: sample_format_reg <= cfg_data[1:0];
                CFG_GAIN_FORMAT:   gain_format_reg   <= cfg_data[0];
                CFG_PEAK_SHIFT:    peak_shift_reg    <= cfg_data[4:0];
                CFG_GAIN_CH0:      gain_reg[0]       <= $signed(cfg_data);
                CFG_GAIN_CH1:      gain_reg[1]       <= $signed(cfg_data);
                CFG_GAIN_CH2:      gain_reg[2]       <= $signed(cfg_data);
                CFG_GAIN_CH3:      gain_reg[3]       <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg    <= x_next;
            a_reg    <= a_next;
            chan_reg <= s_data.chan;
            clr_reg  <= s_data.period_start;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.sample_out <= y;
            m_data_reg.chan_out   <= chan_reg;
            m_data_reg.peak_level <= peak_level;
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PCM gain and peak meter core. A short table of
// directed requests runs first: reset values, sample and gain extremes, each
// sample format including code three, and peak clear on period start. Random
// requests follow, in phases that each rewrite every register. Each result is
// compared field by field against a written-in expectation or a predictor of the
// scaled sample and channel peak. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
    import pgpm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 400_000;
    localparam int          PHASES       = 15;
    localparam int          PHASE_ITEMS  = 95;
    localparam logic [1:0]  FMT_ALT_S32  = 2'd3;
    localparam longint      LMAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      SAT32_MAX    = 64'sd2147483647;
    localparam longint      SAT32_MIN    = -64'sd2147483648;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          wdata;
        in_item_t             item;
        bit                   typed;
        out_item_t            want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the block's registers and peaks
    logic [1:0]         fmt_q;
    logic               gfmt_q;
    logic [4:0]         shift_q;
    logic signed [31:0] gain_q [GAIN_REGS];
    logic [30:0]        peak_q [PGPM_CHANNELS];

    out_item_t due_samples [$];
    plan_row_t plan [$];
    int        errors      = 0;
    int        cycle_count = 0;
    int        src_calm    = 0;
    int        snk_calm    = 0;

    pcm_gain_with_peak_meter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // half away from zero
    function automatic longint round_sym(longint v, int sh);
        longint mag;
        longint r;
        mag = v < 0 ? -v : v;
        r = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return v < 0 ? -r : r;
    endfunction

    function automatic out_item_t scale_and_meter(in_item_t it);
        longint    g;
        longint    a;
        longint    x;
        longint    p;
        longint    t;
        longint    y;
        longint    mag;
        longint    pk;
        out_item_t r;
        g = gain_q[it.chan];
        a = (gfmt_q == GFMT_Q1_23) ? g : clip(g * 128, SAT32_MIN, SAT32_MAX);
        case (fmt_q)
            FMT_S16: begin
                x = $signed(it.sample_in[15:0]);
                t = clip(round_sym(a * x, 15), SAT32_MIN, SAT32_MAX);
                t = clip(t * 256, SAT32_MIN, SAT32_MAX);
                y = clip(round_sym(t, 16), -64'sd32768, 64'sd32767);
            end
            FMT_S24: begin
                x = $signed(it.sample_in[23:0]);
                t = clip(round_sym(a * (x * 256), 31), SAT32_MIN, SAT32_MAX);
                y = clip(t, -64'sd8388608, 64'sd8388607);
            end
            default: begin
                x = longint'($signed(it.sample_in));
                p = g * x;
                p = (p == (longint'(1) <<< 62)) ? LMAX : p * 2;
                t = p >>> ((gfmt_q == GFMT_Q1_23) ? 8 : 1);
                y = clip(round_sym(t, 16), SAT32_MIN, SAT32_MAX);
            end
        endcase
        mag = x < 0 ? -x : x;
        if (mag > SAT32_MAX) mag = SAT32_MAX;
        if (it.period_start) peak_q[it.chan] = '0;
        if (mag > longint'(peak_q[it.chan])) peak_q[it.chan] = mag[30:0];
        pk = longint'(peak_q[it.chan]);
        if (fmt_q != FMT_S16) begin
            pk = pk << shift_q;
            if (pk > SAT32_MAX) pk = SAT32_MAX;
        end
        r.sample_out = y[31:0];
        r.chan_out   = it.chan;
        r.peak_level = pk[30:0];
        return r;
    endfunction

    function automatic void add_sample(logic [31:0] s, logic [1:0] c, logic ps, bit typed,
                                       logic [31:0] want_s, logic [30:0] want_pk);
        plan_row_t row;
        row = '{default: '0};
        row.item.sample_in    = s;
        row.item.chan         = c;
        row.item.period_start = ps;
        row.typed             = typed;
        row.want.sample_out   = want_s;
        row.want.chan_out     = c;
        row.want.peak_level   = want_pk;
        plan.push_back(row);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.wdata    = d;
        plan.push_back(row);
    endfunction

    // random wait, with runs of back-to-back transfers
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [31:0] draw_sample();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 8))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_7FFF;
                    5: v = 32'hFFFF_8000;
                    6: v = 32'h007F_FFFF;
                    7: v = 32'hFF80_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            1: v = $urandom;
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] draw_gain();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 8))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0001_0000;
                    4: v = 32'h0080_0000;
                    5: v = 32'hFF80_0000;
                    6: v = 32'hFFFF_0000;
                    7: v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1: v = $urandom;
            default: begin
                v = $urandom >> $urandom_range(6, 16);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic flag(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_sample(out_item_t got);
        out_item_t want;
        if (due_samples.size() == 0) begin
            flag($sformatf("result with nothing pending: %h", got));
        end else begin
            want = due_samples.pop_front();
            if (got.sample_out !== want.sample_out)
                flag($sformatf("sample_out %h, expected %h", got.sample_out, want.sample_out));
            if (got.chan_out !== want.chan_out)
                flag($sformatf("chan_out %0d, expected %0d", got.chan_out, want.chan_out));
            if (got.peak_level !== want.peak_level)
                flag($sformatf("peak_level %h, expected %h (chan %0d)",
                               got.peak_level, want.peak_level, want.chan_out));
        end
    endtask

    // one request; valid held until accepted
    task automatic send_sample(in_item_t it, bit typed, out_item_t want);
        int        gap;
        out_item_t got;
        cfg_valid <= 1'b0;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        got = scale_and_meter(it);
        due_samples.push_back(typed ? want : got);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SAMPLE_FORMAT: fmt_q   = d[1:0];
            CFG_GAIN_FORMAT:   gfmt_q  = d[0];
            CFG_PEAK_SHIFT:    shift_q = d[4:0];
            CFG_GAIN_CH0:      gain_q[0] = d;
            CFG_GAIN_CH1:      gain_q[1] = d;
            CFG_GAIN_CH2:      gain_q[2] = d;
            CFG_GAIN_CH3:      gain_q[3] = d;
            default: ;
        endcase
    endtask

    task automatic await_idle();
        s_valid <= 1'b0;
        while (due_samples.size() != 0) @(posedge aclk);
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : sink
        out_item_t got;
        int        stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(snk_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = m_data;
            check_sample(got);
        end
    end

    initial begin : stimulus
        in_item_t it;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fmt_q     = FMT_S32;
        gfmt_q    = GFMT_Q8_16;
        shift_q   = '0;
        foreach (gain_q[i]) gain_q[i] = GAIN_RESET;
        foreach (peak_q[i]) peak_q[i] = '0;

        // reset settings: s32, unity gain, no peak shift
        add_sample(32'h0000_0000, 2'd0, 1'b0, 1'b1, 32'h0000_0000, 31'h0);
        add_sample(32'h7FFF_FFFF, 2'd1, 1'b0, 1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_sample(32'h8000_0000, 2'd2, 1'b0, 1'b1, 32'h8000_0000, 31'h7FFF_FFFF);
        add_sample(32'hFFFF_FFFB, 2'd3, 1'b0, 1'b1, 32'hFFFF_FFFB, 31'd5);
        add_sample(32'h0000_0003, 2'd3, 1'b0, 1'b1, 32'h0000_0003, 31'd5);
        add_sample(32'h0000_0002, 2'd3, 1'b1, 1'b1, 32'h0000_0002, 31'd2);
        add_write(CFG_GAIN_FORMAT, 32'(GFMT_Q1_23));
        add_write(CFG_GAIN_CH0, 32'h8000_0000);
        add_write(CFG_GAIN_CH1, 32'h7FFF_FFFF);
        add_sample(32'h8000_0000, 2'd0, 1'b0, 1'b0, '0, '0);
        add_sample(32'h7FFF_FFFF, 2'd0, 1'b0, 1'b0, '0, '0);
        add_sample(32'h8000_0000, 2'd1, 1'b0, 1'b0, '0, '0);
        add_sample(32'h7FFF_FFFF, 2'd1, 1'b0, 1'b0, '0, '0);
        add_write(CFG_SAMPLE_FORMAT, 32'(FMT_S24));
        add_write(CFG_GAIN_FORMAT, 32'(GFMT_Q8_16));
        add_write(CFG_PEAK_SHIFT, 32'd31);
        add_sample(32'hAB80_0000, 2'd2, 1'b0, 1'b0, '0, '0);
        add_sample(32'h007F_FFFF, 2'd1, 1'b0, 1'b0, '0, '0);
        add_sample(32'hFF00_0001, 2'd0, 1'b1, 1'b0, '0, '0);
        add_write(CFG_SAMPLE_FORMAT, 32'(FMT_S16));
        add_write(CFG_PEAK_SHIFT, 32'd4);
        add_sample(32'hFFFF_8000, 2'd1, 1'b0, 1'b0, '0, '0);
        add_sample(32'h1234_7FFF, 2'd0, 1'b0, 1'b0, '0, '0);
        add_sample(32'h0000_0001, 2'd3, 1'b1, 1'b0, '0, '0);
        add_write(CFG_SAMPLE_FORMAT, 32'(FMT_ALT_S32));
        add_write(CFG_GAIN_FORMAT, 32'(GFMT_Q1_23));
        add_write(CFG_PEAK_SHIFT, 32'd1);
        add_sample(32'h4000_0000, 2'd2, 1'b0, 1'b0, '0, '0);
        add_sample(32'hC000_0001, 2'd3, 1'b1, 1'b0, '0, '0);
        add_write(CFG_GAIN_CH2, 32'h0000_0000);
        add_write(CFG_GAIN_CH3, 32'hFFFF_0000);
        add_sample(32'h1234_5678, 2'd2, 1'b0, 1'b0, '0, '0);
        add_sample(32'h8000_0000, 2'd3, 1'b0, 1'b0, '0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                if (i == 0 || !plan[i-1].is_write) await_idle();
                write_reg(plan[i].idx, plan[i].wdata);
            end else begin
                send_sample(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            await_idle();
            write_reg(CFG_SAMPLE_FORMAT, 32'(ph % 4));
            write_reg(CFG_GAIN_FORMAT, 32'((ph / 4) % 2));
            write_reg(CFG_PEAK_SHIFT,
                      ph == 0 ? 32'd0 : (ph == 1 ? 32'd31 : 32'($urandom_range(0, 31))));
            for (int c = 0; c < GAIN_REGS; c++)
                write_reg(CFG_GAIN_CH0 + CFG_IDX_W'(c), draw_gain());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it.sample_in    = draw_sample();
                it.chan         = 2'($urandom_range(0, 3));
                it.period_start = ($urandom_range(0, 9) == 0);
                send_sample(it, 1'b0, '0);
            end
        end

        await_idle();
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
